>>> hdl/ctl_pkg.sv
// Shared constants and types for the closed tour length evaluator.
package ctl_pkg;

  // Defaults for the top-level parameters.
  localparam int CitiesDef   = 16;
  localparam int DistBitsDef = 20;

  // Fixed field widths of the item ports.
  localparam int CityW     = 4;
  localparam int DistFldW  = 20;
  localparam int SumW      = 24;
  localparam int CityField = 1 << CityW;

  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_CITY  = 1'b1
  } cmd_e;

  // Control that travels with the table read into the accumulate stage.
  typedef struct packed {
    logic valid;
    logic first;   // first city of a tour: the running sum restarts
    logic last;    // closing city: the return leg is added and the total issued
    logic a_ok;    // previous -> city leg lies inside the table
    logic b_ok;    // city -> first leg lies inside the table
  } acc_ctl_t;

endpackage

>>> hdl/ctl_ram.sv
// Generic synchronous RAM with one write port and two registered read ports.
module ctl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

>>> hdl/closed_tour_length.sv
// Closed tour length evaluator: distance table in RAM, tour accumulator, output register.
//
// Usage: one input channel (in_valid_i / in_stall_o) carries words of two kinds.
// A write word (command_i = 0) stores distance_i at table entry (row_i, col_i);
// entries outside the CITIES x CITIES table are dropped. A tour word
// (command_i = 1) names the next city; the distance from the previous city is
// added, and on the word with last_city_i set the return leg to the first city
// is added as well and the total goes out on tour_length_o (out_valid_o /
// out_stall_i). A tour of one city gives that city's self-distance.
// Throughput: one word per cycle while in_stall_o is low. Each tour word reads
// both legs at once from the dual-read table through the registered RAM read
// ports, then passes through the accumulator into the output register. A table
// write is visible to any tour word accepted after it. Reset clears the tour
// state and out_valid_o but not the tour_length_o register; the table holds no
// valid data until written. While a result waits under out_stall_i and the
// accumulator holds another closing total, in_stall_o rises and the whole
// pipeline freezes.
module closed_tour_length
  import ctl_pkg::*;
#(
  parameter int CITIES    = CitiesDef,
  parameter int DIST_BITS = DistBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                command_i,
  input  logic [CityW-1:0]    row_i,
  input  logic [CityW-1:0]    col_i,
  input  logic [DistFldW-1:0] distance_i,
  input  logic [CityW-1:0]    city_i,
  input  logic                last_city_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SumW-1:0]     tour_length_o
);

  // Only cities reachable through the 4-bit fields need table space.
  localparam int EffCities = (CITIES < CityField) ? CITIES : CityField;
  localparam int Depth     = EffCities * EffCities;
  localparam int AddrW     = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int WideW     = (DIST_BITS > DistFldW) ? DIST_BITS : DistFldW;
  localparam int AddW      = ((DIST_BITS > SumW) ? DIST_BITS : SumW) + 2;
  localparam logic [AddW-1:0] SumMaxExt = AddW'(SumMax);

  logic             hold;
  logic             accept;
  logic             is_city;
  logic             wr_en;
  logic [WideW-1:0] dist_wide;
  logic [AddrW-1:0] waddr;
  logic [AddrW-1:0] raddr_a;
  logic [AddrW-1:0] raddr_b;
  logic [DIST_BITS-1:0] rdata_a;
  logic [DIST_BITS-1:0] rdata_b;
  logic [CityW-1:0] first_src;
  logic             city_ok;
  logic             prev_ok;
  logic             first_ok;

  logic             started_q, started_d;
  logic [CityW-1:0] first_q, first_d;
  logic [CityW-1:0] prev_q, prev_d;
  acc_ctl_t         acc_q, acc_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic             out_valid_q, out_valid_d;
  logic [SumW-1:0]  out_len_q, out_len_d;

  logic [AddW-1:0]  base;
  logic [AddW-1:0]  term_a;
  logic [AddW-1:0]  term_b;
  logic [AddW-1:0]  total;
  logic [SumW-1:0]  total_sat;
  logic             acc_fire;

  // The accumulator may not retire a second total while one still waits.
  assign hold       = acc_q.valid && acc_q.last && out_valid_q && out_stall_i;
  assign in_stall_o = hold;
  assign accept     = in_valid_i && !hold;
  assign is_city    = (cmd_e'(command_i) == CMD_CITY);

  assign dist_wide = WideW'(distance_i);
  assign wr_en     = accept && !is_city &&
                     (32'(row_i) < CITIES) && (32'(col_i) < CITIES);
  assign waddr     = AddrW'(32'(row_i) * EffCities + 32'(col_i));

  assign first_src = started_q ? first_q : city_i;
  assign city_ok   = (32'(city_i) < CITIES);
  assign prev_ok   = (32'(prev_q) < CITIES);
  assign first_ok  = (32'(first_src) < CITIES);
  assign raddr_a   = AddrW'(32'(prev_q) * EffCities + 32'(city_i));
  assign raddr_b   = AddrW'(32'(city_i) * EffCities + 32'(first_src));

  ctl_ram #(
    .Width (DIST_BITS),
    .Depth (Depth)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (waddr),
    .wdata_i   (dist_wide[DIST_BITS-1:0]),
    .re_i      (!hold),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // Tour bookkeeping advances at acceptance; only the sum waits for the RAM.
  always_comb begin
    started_d = started_q;
    first_d   = first_q;
    prev_d    = prev_q;
    acc_d     = '0;
    if (accept && is_city) begin
      started_d   = !last_city_i;
      first_d     = first_src;
      prev_d      = city_i;
      acc_d.valid = 1'b1;
      acc_d.first = !started_q;
      acc_d.last  = last_city_i;
      acc_d.a_ok  = prev_ok && city_ok;
      acc_d.b_ok  = city_ok && first_ok;
    end
  end

  // Saturation of the two-step sum equals saturation of the three-term sum.
  assign base      = acc_q.first ? '0 : AddW'(sum_q);
  assign term_a    = (!acc_q.first && acc_q.a_ok) ? AddW'(rdata_a) : '0;
  assign term_b    = (acc_q.last && acc_q.b_ok) ? AddW'(rdata_b) : '0;
  assign total     = base + term_a + term_b;
  assign total_sat = (total > SumMaxExt) ? SumMax : total[SumW-1:0];
  assign acc_fire  = acc_q.valid && !hold;

  always_comb begin
    sum_d       = sum_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_len_d   = out_len_q;
    if (acc_fire) begin
      sum_d = total_sat;
      if (acc_q.last) begin
        out_valid_d = 1'b1;
        out_len_d   = total_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      first_q     <= '0;
      prev_q      <= '0;
      acc_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      started_q   <= started_d;
      first_q     <= first_d;
      prev_q      <= prev_d;
      if (!hold) begin
        acc_q <= acc_d;
      end
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_len_q <= out_len_d;
  end

  assign out_valid_o   = out_valid_q;
  assign tour_length_o = out_len_q;

endmodule

>>> hdl/ctl_checker.sv
// Port-level checker for the closed tour length evaluator, bound to the top level.
module ctl_checker
  import ctl_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                command_i,
  input logic                last_city_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [SumW-1:0]     tour_length_o
);

  // A stalled result word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(tour_length_o))
    else $error("result word changed while stalled");

  // The input side is only held back by a full output under stall.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // A new result appears only for a closing tour word that was taken, after its table read and accumulation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o &&
                                 (cmd_e'(command_i) == CMD_CITY) && last_city_i, 2))
    else $error("result without a closing tour word");

endmodule

bind closed_tour_length ctl_checker u_ctl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .command_i     (command_i),
  .last_city_i   (last_city_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .tour_length_o (tour_length_o)
);
